[hw/rtl/tbb_pkg.sv]
// Shared types and constants for the transformed box bounds block.
// Used by the lane, merge and top-level modules. No dependencies.
package tbb_pkg;

   localparam int FRAC_SHIFT      = 12;
   localparam int COEFF_REG_WIDTH = 48;
   localparam int SHIFT_REG_WIDTH = 32;
   localparam int CSR_DATA_WIDTH  = 48;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NUM_AXES        = 3;
   localparam int UNITY_COEFF     = 4096;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROW_X   = 3'd0,
      REG_ROW_Y   = 3'd1,
      REG_ROW_Z   = 3'd2,
      REG_SHIFT_X = 3'd3,
      REG_SHIFT_Y = 3'd4,
      REG_SHIFT_Z = 3'd5
   } csr_index_type;

   // per-stage load enables of the pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

[hw/rtl/tbb_ifs.sv]
// Valid/ready channel interfaces for box items and bound items.
// No dependencies.
interface tbb_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] lo_x;
   logic signed [COORD_WIDTH-1:0] lo_y;
   logic signed [COORD_WIDTH-1:0] lo_z;
   logic signed [COORD_WIDTH-1:0] hi_x;
   logic signed [COORD_WIDTH-1:0] hi_y;
   logic signed [COORD_WIDTH-1:0] hi_z;

   modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
   modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface tbb_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_lo_x;
   logic signed [COORD_WIDTH-1:0] out_lo_y;
   logic signed [COORD_WIDTH-1:0] out_lo_z;
   logic signed [COORD_WIDTH-1:0] out_hi_x;
   logic signed [COORD_WIDTH-1:0] out_hi_y;
   logic signed [COORD_WIDTH-1:0] out_hi_z;

   modport source (output valid, out_lo_x, out_lo_y, out_lo_z,
                   out_hi_x, out_hi_y, out_hi_z, input ready);
   modport sink   (input valid, out_lo_x, out_lo_y, out_lo_z,
                   input out_hi_x, out_hi_y, out_hi_z, output ready);
endinterface

[hw/rtl/transformed_box_bounds.sv]
// Transformed box bounds top level: configuration registers, pipeline control,
// three column lanes and the merge stage. Uses tbb_pkg, tbb_ifs, tbb_lane, tbb_merge.
//
// Takes one box per clock while the pipeline is not stalled and returns its bounds
// after the configured affine transform. The corners combine the axes independently,
// so the min and max over the eight corners equal the per-term extremes summed;
// three column lanes form those terms with 18 COORD_WIDTH x COEFF_WIDTH multipliers
// (stage 1), pick the smaller and larger term (stage 2), and the merge stage adds
// the translation and saturates into the output register (stage 3). Each stage
// moves whenever the one after it has room, so bubbles close up and a new item is
// taken while a result waits. Reset loads the identity matrix and zero translation.
module transformed_box_bounds
   import tbb_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int COEFF_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   tbb_req_if.sink                    req_bus,
   tbb_rsp_if.source                  rsp_bus
);

   localparam int TW    = COORD_WIDTH + COEFF_WIDTH - FRAC_SHIFT;
   localparam int ROW_W = (3 * COEFF_WIDTH > COEFF_REG_WIDTH) ? 3 * COEFF_WIDTH
                                                                 : COEFF_REG_WIDTH;
   localparam logic [ROW_W-1:0] UNITY = ROW_W'(UNITY_COEFF);

   logic [ROW_W-1:0]           row_ff [NUM_AXES];
   logic [ROW_W-1:0]           row_in [NUM_AXES];
   logic [SHIFT_REG_WIDTH-1:0] shift_ff [NUM_AXES];
   logic [SHIFT_REG_WIDTH-1:0] shift_in [NUM_AXES];

   logic         v1_ff, v2_ff, v3_ff;
   logic         v1_in, v2_in, v3_in;
   stage_en_type stage_en;

   logic signed [COORD_WIDTH-1:0] lane_lo [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] lane_hi [NUM_AXES];
   logic signed [COEFF_WIDTH-1:0] lane_coeff [NUM_AXES][NUM_AXES];
   logic signed [TW-1:0]          term_min [NUM_AXES][NUM_AXES];
   logic signed [TW-1:0]          term_max [NUM_AXES][NUM_AXES];
   logic signed [COORD_WIDTH-1:0] shift_cw [NUM_AXES];
   logic [63:0]                   shift_ext [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] bound_lo [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] bound_hi [NUM_AXES];

   // configuration registers
   always_comb begin
      row_in   = row_ff;
      shift_in = shift_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_ROW_X:   row_in[0]   = ROW_W'(csr_wdata);
            REG_ROW_Y:   row_in[1]   = ROW_W'(csr_wdata);
            REG_ROW_Z:   row_in[2]   = ROW_W'(csr_wdata);
            REG_SHIFT_X: shift_in[0] = csr_wdata[SHIFT_REG_WIDTH-1:0];
            REG_SHIFT_Y: shift_in[1] = csr_wdata[SHIFT_REG_WIDTH-1:0];
            REG_SHIFT_Z: shift_in[2] = csr_wdata[SHIFT_REG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0]   <= UNITY;
         row_ff[1]   <= UNITY << COEFF_WIDTH;
         row_ff[2]   <= UNITY << (2 * COEFF_WIDTH);
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else begin
         row_ff   <= row_in;
         shift_ff <= shift_in;
      end
   end

   // pipeline control
   always_comb begin
      stage_en.s3   = !v3_ff || rsp_bus.ready;
      stage_en.s2   = !v2_ff || stage_en.s3;
      stage_en.s1   = !v1_ff || stage_en.s2;
      req_bus.ready = stage_en.s1;
      v1_in = stage_en.s1 ? req_bus.valid : v1_ff;
      v2_in = stage_en.s2 ? v1_ff : v2_ff;
      v3_in = stage_en.s3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // lane k handles input axis k against column k of every row
   always_comb begin
      lane_lo[0] = req_bus.lo_x;
      lane_lo[1] = req_bus.lo_y;
      lane_lo[2] = req_bus.lo_z;
      lane_hi[0] = req_bus.hi_x;
      lane_hi[1] = req_bus.hi_y;
      lane_hi[2] = req_bus.hi_z;
      for (int k = 0; k < NUM_AXES; k++)
         for (int r = 0; r < NUM_AXES; r++)
            lane_coeff[k][r] = row_ff[r][k*COEFF_WIDTH +: COEFF_WIDTH];
      for (int a = 0; a < NUM_AXES; a++) begin
         shift_ext[a] = 64'(shift_ff[a]);
         shift_cw[a]  = shift_ext[a][COORD_WIDTH-1:0];
      end
   end

   for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      tbb_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .COEFF_WIDTH (COEFF_WIDTH)
      ) u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .lo       (lane_lo[k]),
         .hi       (lane_hi[k]),
         .coeff    (lane_coeff[k]),
         .term_min (term_min[k]),
         .term_max (term_max[k])
      );
   end

   tbb_merge #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
   ) u_merge (
      .clock    (clock),
      .stage_en (stage_en),
      .term_min (term_min),
      .term_max (term_max),
      .shift    (shift_cw),
      .bound_lo (bound_lo),
      .bound_hi (bound_hi)
   );

   assign rsp_bus.valid    = v3_ff;
   assign rsp_bus.out_lo_x = bound_lo[0];
   assign rsp_bus.out_lo_y = bound_lo[1];
   assign rsp_bus.out_lo_z = bound_lo[2];
   assign rsp_bus.out_hi_x = bound_hi[0];
   assign rsp_bus.out_hi_y = bound_hi[1];
   assign rsp_bus.out_hi_z = bound_hi[2];

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (v1_ff && v2_ff && v3_ff))
      else $error("input stalled with a free pipeline slot");

   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> v1_ff)
      else $error("accepted item lost at stage 1");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.out_lo_x <= rsp_bus.out_hi_x)
                     && (rsp_bus.out_lo_y <= rsp_bus.out_hi_y)
                     && (rsp_bus.out_lo_z <= rsp_bus.out_hi_z))
      else $error("result lower bound exceeds upper bound");

   a_stage3_advances: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !v3_ff) |=> v3_ff)
      else $error("item not moved into output register");

endmodule

[hw/rtl/tbb_lane.sv]
// Column lane: multiplies one input axis (lo and hi) by its coefficient in each
// matrix row, floors by FRAC_SHIFT and keeps the smaller and larger term. Uses tbb_pkg.
module tbb_lane
   import tbb_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int COEFF_WIDTH = 16
) (
   input  logic                     clock,
   input  stage_en_type             stage_en,
   input  logic signed [COORD_WIDTH-1:0] lo,
   input  logic signed [COORD_WIDTH-1:0] hi,
   input  logic signed [COEFF_WIDTH-1:0] coeff [NUM_AXES],
   output logic signed [COORD_WIDTH+COEFF_WIDTH-FRAC_SHIFT-1:0] term_min [NUM_AXES],
   output logic signed [COORD_WIDTH+COEFF_WIDTH-FRAC_SHIFT-1:0] term_max [NUM_AXES]
);

   localparam int PW = COORD_WIDTH + COEFF_WIDTH;
   localparam int TW = PW - FRAC_SHIFT;

   logic signed [PW-1:0] prod_lo_in [NUM_AXES];
   logic signed [PW-1:0] prod_hi_in [NUM_AXES];
   logic signed [PW-1:0] prod_lo_ff [NUM_AXES];
   logic signed [PW-1:0] prod_hi_ff [NUM_AXES];
   logic signed [TW-1:0] t_lo [NUM_AXES];
   logic signed [TW-1:0] t_hi [NUM_AXES];
   logic signed [TW-1:0] tmin_ff [NUM_AXES];
   logic signed [TW-1:0] tmax_ff [NUM_AXES];

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         prod_lo_in[r] = PW'(lo) * PW'(coeff[r]);
         prod_hi_in[r] = PW'(hi) * PW'(coeff[r]);
         // dropping the low bits of a two's complement value floors it
         t_lo[r] = prod_lo_ff[r][PW-1:FRAC_SHIFT];
         t_hi[r] = prod_hi_ff[r][PW-1:FRAC_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (stage_en.s2) begin
         for (int r = 0; r < NUM_AXES; r++) begin
            if (t_lo[r] < t_hi[r]) begin
               tmin_ff[r] <= t_lo[r];
               tmax_ff[r] <= t_hi[r];
            end else begin
               tmin_ff[r] <= t_hi[r];
               tmax_ff[r] <= t_lo[r];
            end
         end
      end
   end

   assign term_min = tmin_ff;
   assign term_max = tmax_ff;

endmodule

[hw/rtl/tbb_merge.sv]
// Merge stage: sums the per-lane extreme terms with the translation of each
// output axis and saturates to COORD_WIDTH. Uses tbb_pkg.
module tbb_merge
   import tbb_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int COEFF_WIDTH = 16
) (
   input  logic         clock,
   input  stage_en_type stage_en,
   input  logic signed [COORD_WIDTH+COEFF_WIDTH-FRAC_SHIFT-1:0]
                        term_min [NUM_AXES][NUM_AXES],
   input  logic signed [COORD_WIDTH+COEFF_WIDTH-FRAC_SHIFT-1:0]
                        term_max [NUM_AXES][NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] shift [NUM_AXES],
   output logic signed [COORD_WIDTH-1:0] bound_lo [NUM_AXES],
   output logic signed [COORD_WIDTH-1:0] bound_hi [NUM_AXES]
);

   localparam int TW = COORD_WIDTH + COEFF_WIDTH - FRAC_SHIFT;
   localparam int SW = ((TW > COORD_WIDTH) ? TW : COORD_WIDTH) + 2;

   localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic signed [SW-1:0]          sum_lo [NUM_AXES];
   logic signed [SW-1:0]          sum_hi [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] lo_in [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] hi_in [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] lo_ff [NUM_AXES];
   logic signed [COORD_WIDTH-1:0] hi_ff [NUM_AXES];

   function automatic logic [COORD_WIDTH-1:0] saturate(input logic [SW-1:0] v);
      logic fits;
      fits = (&v[SW-1:COORD_WIDTH-1]) || !(|v[SW-1:COORD_WIDTH-1]);
      if (fits)
         return v[COORD_WIDTH-1:0];
      else if (v[SW-1])
         return SAT_MIN;
      else
         return SAT_MAX;
   endfunction

   // lane index first, output axis second
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sum_lo[a] = {{(SW-COORD_WIDTH){shift[a][COORD_WIDTH-1]}}, shift[a]};
         sum_hi[a] = sum_lo[a];
         for (int k = 0; k < NUM_AXES; k++) begin
            sum_lo[a] = sum_lo[a] + {{(SW-TW){term_min[k][a][TW-1]}}, term_min[k][a]};
            sum_hi[a] = sum_hi[a] + {{(SW-TW){term_max[k][a][TW-1]}}, term_max[k][a]};
         end
         lo_in[a] = saturate(sum_lo[a]);
         hi_in[a] = saturate(sum_hi[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign bound_lo = lo_ff;
   assign bound_hi = hi_ff;

endmodule

[tb/tb.sv]
// Testbench for transformed_box_bounds: random and corner-case boxes through several
// affine settings, checked against a predictor of the transform and its min/max bounds.
// Depends on tbb_pkg, tbb_ifs and the transformed_box_bounds RTL.
module tb;
   import tbb_pkg::*;

   localparam int COORD_W     = 32;
   localparam int COEFF_W     = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int MAX_REPORTS = 40;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;
   localparam longint SAT_HI = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;
   localparam logic [COEFF_W-1:0] COEFF_MOST_NEG = 16'h8000;
   localparam logic [COEFF_W-1:0] COEFF_MOST_POS = 16'h7fff;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic signed [COORD_W-1:0] lo_x;
      logic signed [COORD_W-1:0] lo_y;
      logic signed [COORD_W-1:0] lo_z;
      logic signed [COORD_W-1:0] hi_x;
      logic signed [COORD_W-1:0] hi_y;
      logic signed [COORD_W-1:0] hi_z;
   } box_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   tbb_req_if #(.COORD_WIDTH(COORD_W)) req_bus ();
   tbb_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_bus ();

   transformed_box_bounds #(
      .COORD_WIDTH(COORD_W),
      .COEFF_WIDTH(COEFF_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus)
   );

   // transform currently loaded in the block
   logic [COEFF_REG_WIDTH-1:0]        row_coeffs [NUM_AXES];
   logic signed [SHIFT_REG_WIDTH-1:0] axis_shift [NUM_AXES];

   box_type boxes_pending [$];
   box_type bounds_due [$];

   int unsigned boxes_queued       = 0;
   int unsigned boxes_accepted     = 0;
   int unsigned bounds_checked     = 0;
   int unsigned mismatch_count     = 0;
   int unsigned saturated_sums     = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned cycle_count        = 0;
   int unsigned req_gap_max;
   int unsigned rsp_stall_max;
   int unsigned req_gap_left;
   int unsigned rsp_stall_left;
   int unsigned hold_left;
   bit          hold_request;
   bit          hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic box_type make_box(logic signed [COORD_W-1:0] lx, ly, lz, hx, hy, hz);
      box_type b;
      b.lo_x = lx;
      b.lo_y = ly;
      b.lo_z = lz;
      b.hi_x = hx;
      b.hi_y = hy;
      b.hi_z = hz;
      return b;
   endfunction

   // bounds of the eight transformed corners, each sum saturated
   function automatic box_type transform_bounds(box_type b);
      longint lo_in [3];
      longint hi_in [3];
      longint corner [3];
      longint mn [3];
      longint mx [3];
      longint sum;
      logic signed [COEFF_W-1:0] cf;
      lo_in[0] = b.lo_x;
      lo_in[1] = b.lo_y;
      lo_in[2] = b.lo_z;
      hi_in[0] = b.hi_x;
      hi_in[1] = b.hi_y;
      hi_in[2] = b.hi_z;
      for (int c = 0; c < 8; c++) begin
         corner[0] = c[2] ? hi_in[0] : lo_in[0];
         corner[1] = c[1] ? hi_in[1] : lo_in[1];
         corner[2] = c[0] ? hi_in[2] : lo_in[2];
         for (int a = 0; a < NUM_AXES; a++) begin
            sum = axis_shift[a];
            for (int k = 0; k < 3; k++) begin
               cf = row_coeffs[a][k*COEFF_W +: COEFF_W];
               sum += (corner[k] * cf) >>> FRAC_SHIFT;
            end
            if (sum > SAT_HI) begin
               sum = SAT_HI;
               saturated_sums++;
            end else if (sum < SAT_LO) begin
               sum = SAT_LO;
               saturated_sums++;
            end
            if (c == 0 || sum < mn[a]) mn[a] = sum;
            if (c == 0 || sum > mx[a]) mx[a] = sum;
         end
      end
      return make_box(COORD_W'(mn[0]), COORD_W'(mn[1]), COORD_W'(mn[2]),
                      COORD_W'(mx[0]), COORD_W'(mx[1]), COORD_W'(mx[2]));
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_coord(string field, logic signed [COORD_W-1:0] got, want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
   endtask

   // driver: offers pending boxes, keeps valid up until taken
   always @(posedge clock) begin : box_driver
      box_type next_box;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.lo_x  <= '0;
         req_bus.lo_y  <= '0;
         req_bus.lo_z  <= '0;
         req_bus.hi_x  <= '0;
         req_bus.hi_y  <= '0;
         req_bus.hi_z  <= '0;
         req_gap_left  <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bounds_due.push_back(transform_bounds(make_box(req_bus.lo_x, req_bus.lo_y,
               req_bus.lo_z, req_bus.hi_x, req_bus.hi_y, req_bus.hi_z)));
            boxes_accepted++;
         end else if (req_bus.valid) begin
            input_stall_cycles++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap_left != 0) begin
               req_bus.valid <= 1'b0;
               req_gap_left  <= req_gap_left - 1;
            end else if (boxes_pending.size() != 0) begin
               next_box = boxes_pending.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.lo_x  <= next_box.lo_x;
               req_bus.lo_y  <= next_box.lo_y;
               req_bus.lo_z  <= next_box.lo_z;
               req_bus.hi_x  <= next_box.hi_x;
               req_bus.hi_y  <= next_box.hi_y;
               req_bus.hi_z  <= next_box.hi_z;
               req_gap_left  <= $urandom_range(0, req_gap_max);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result against the oldest prediction
   always @(posedge clock) begin : bounds_monitor
      box_type got;
      box_type want;
      int unsigned stall_next;
      if (reset) begin
         rsp_bus.ready  <= 1'b0;
         rsp_stall_left <= 0;
      end else begin
         stall_next = (rsp_stall_left != 0) ? rsp_stall_left - 1 : 0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = make_box(rsp_bus.out_lo_x, rsp_bus.out_lo_y, rsp_bus.out_lo_z,
                           rsp_bus.out_hi_x, rsp_bus.out_hi_y, rsp_bus.out_hi_z);
            if (bounds_due.size() == 0) begin
               report_mismatch("result with no box outstanding");
            end else begin
               want = bounds_due.pop_front();
               bounds_checked++;
               check_coord("out_lo_x", got.lo_x, want.lo_x);
               check_coord("out_lo_y", got.lo_y, want.lo_y);
               check_coord("out_lo_z", got.lo_z, want.lo_z);
               check_coord("out_hi_x", got.hi_x, want.hi_x);
               check_coord("out_hi_y", got.hi_y, want.hi_y);
               check_coord("out_hi_z", got.hi_z, want.hi_z);
            end
            stall_next = $urandom_range(0, rsp_stall_max);
         end
         rsp_stall_left <= stall_next;
         rsp_bus.ready  <= (stall_next == 0) && (hold_left == 0);
      end
   end

   // one long output hold-off so the pipeline fills and backs up
   always @(posedge clock) begin : output_hold
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                            logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_ROW_X, REG_ROW_Y, REG_ROW_Z:
            row_coeffs[2'(index)] = data[COEFF_REG_WIDTH-1:0];
         REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z:
            axis_shift[2'(index - REG_SHIFT_X)] = data[SHIFT_REG_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // translations carry junk in the unused upper bits
   task automatic load_transform(logic [COEFF_REG_WIDTH-1:0] rx, ry, rz,
                                 logic [SHIFT_REG_WIDTH-1:0] sx, sy, sz);
      write_reg(REG_ROW_X, rx);
      write_reg(REG_ROW_Y, ry);
      write_reg(REG_ROW_Z, rz);
      write_reg(REG_SHIFT_X, {16'($urandom()), sx});
      write_reg(REG_SHIFT_Y, {16'($urandom()), sy});
      write_reg(REG_SHIFT_Z, {16'($urandom()), sz});
   endtask

   function automatic logic [COEFF_REG_WIDTH-1:0] rand_row(bit near_unity);
      logic [COEFF_REG_WIDTH-1:0] row;
      row = COEFF_REG_WIDTH'({$urandom(), $urandom()});
      if (near_unity)
         for (int k = 0; k < 3; k++)
            row[k*COEFF_W +: COEFF_W] =
               COEFF_W'($urandom_range(0, 2 * UNITY_COEFF) - UNITY_COEFF);
      return row;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return r;
         5, 6: return COORD_W'($signed(r[20:0]));
         7: begin
            case (r[1:0])
               2'd0:    return COORD_MAX;
               2'd1:    return COORD_MIN;
               2'd2:    return '0;
               default: return '1;
            endcase
         end
         default: return COORD_W'($signed(r[15:0])) <<< 16;
      endcase
   endfunction

   function automatic box_type rand_box();
      logic signed [COORD_W-1:0] v [6];
      logic signed [COORD_W-1:0] t;
      bit ordered;
      ordered = $urandom_range(0, 9) < 7;
      for (int i = 0; i < 6; i++) v[i] = rand_coord();
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(0, 19) == 0) v[i+3] = v[i];
         if (ordered && v[i] > v[i+3]) begin
            t      = v[i];
            v[i]   = v[i+3];
            v[i+3] = t;
         end
      end
      return make_box(v[0], v[1], v[2], v[3], v[4], v[5]);
   endfunction

   task automatic queue_box(box_type b);
      boxes_pending.push_back(b);
      boxes_queued++;
   endtask

   task automatic queue_random(int unsigned count);
      for (int unsigned i = 0; i < count; i++) queue_box(rand_box());
   endtask

   task automatic queue_corner_boxes();
      queue_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      queue_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      queue_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      queue_box(make_box(-1, -1, -1, 1, 1, 1));
      queue_box(make_box(0, 0, 0, 0, 0, 0));
   endtask

   task automatic set_idling(int unsigned mode);
      case (mode % 4)
         0: begin req_gap_max = 7; rsp_stall_max = 7; end
         1: begin req_gap_max = 0; rsp_stall_max = 0; end
         2: begin req_gap_max = 0; rsp_stall_max = 7; end
         default: begin req_gap_max = 7; rsp_stall_max = 0; end
      endcase
   endtask

   task automatic wait_drained();
      while (boxes_accepted != boxes_queued || bounds_checked != boxes_accepted)
         @(posedge clock);
   endtask

   initial begin : test_sequence
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      hold_request  = 1'b0;
      set_idling(0);
      row_coeffs[0] = COEFF_REG_WIDTH'(UNITY_COEFF);
      row_coeffs[1] = COEFF_REG_WIDTH'(UNITY_COEFF) << COEFF_W;
      row_coeffs[2] = COEFF_REG_WIDTH'(UNITY_COEFF) << (2 * COEFF_W);
      for (int a = 0; a < NUM_AXES; a++) axis_shift[a] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // identity after reset: extremes, inverted and degenerate boxes
      queue_box(make_box(0, 0, 0, 0, 0, 0));
      queue_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      queue_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
      queue_box(make_box(-1, -1, -1, 1, 1, 1));
      queue_box(make_box(5 <<< 16, 6 <<< 16, 7 <<< 16, 1 <<< 16, 2 <<< 16, 3 <<< 16));
      queue_box(make_box(-3 <<< 16, 32'sh00008000, COORD_MIN, 2 <<< 16, -1, COORD_MAX));
      queue_box(make_box(32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff,
                         32'shaaaaaaaa, 32'sh55555555, 32'shffff0000));
      queue_random(100);
      wait_drained();

      // full random transform; spare indexes must be ignored
      load_transform(rand_row(0), rand_row(0), rand_row(0), $urandom(), $urandom(), $urandom());
      write_reg(REG_SPARE_LO, CSR_DATA_WIDTH'({$urandom(), $urandom()}));
      write_reg(REG_SPARE_HI, CSR_DATA_WIDTH'({$urandom(), $urandom()}));
      set_idling(1);
      queue_random(120);
      wait_drained();

      load_transform({3{COEFF_MOST_NEG}}, {3{COEFF_MOST_NEG}}, {3{COEFF_MOST_NEG}},
                     COORD_MAX, COORD_MAX, COORD_MAX);
      set_idling(2);
      queue_corner_boxes();
      queue_random(100);
      wait_drained();

      load_transform({3{COEFF_MOST_POS}}, {3{COEFF_MOST_POS}}, {3{COEFF_MOST_POS}},
                     COORD_MIN, COORD_MIN, COORD_MIN);
      set_idling(3);
      queue_corner_boxes();
      queue_random(100);
      wait_drained();

      load_transform('0, '0, '0, $urandom(), $urandom(), $urandom());
      set_idling(4);
      queue_random(60);
      wait_drained();

      // near-unity transform, back-to-back input with a long output hold-off
      load_transform(rand_row(1), rand_row(1), rand_row(1),
                     COORD_W'($signed($urandom_range(0, 2 ** 22) - 2 ** 21)),
                     COORD_W'($signed($urandom_range(0, 2 ** 22) - 2 ** 21)),
                     COORD_W'($signed($urandom_range(0, 2 ** 22) - 2 ** 21)));
      set_idling(5);
      hold_request = 1'b1;
      queue_random(150);
      wait_drained();

      load_transform(rand_row(0), rand_row(0), rand_row(0), $urandom(), $urandom(), $urandom());
      set_idling(6);
      queue_random(120);
      wait_drained();

      repeat (8) @(posedge clock);
      if (bounds_due.size() != 0) report_mismatch("predicted bounds never returned");
      $display("tb: %0d boxes checked over 7 transforms, %0d saturated corner sums",
               bounds_checked, saturated_sums);
      $display("tb: input back-pressured %0d cycles, %0d mismatches",
               input_stall_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tbb_pkg.sv
hw/rtl/tbb_ifs.sv
hw/rtl/tbb_lane.sv
hw/rtl/tbb_merge.sv
hw/rtl/transformed_box_bounds.sv
tb/tb.sv
